FILE: hdl/rvex_pkg.sv
// rvex_pkg: shared types and constants of the rv32i execute unit
// operation codes, access sizes, write-back port and result record
// no dependencies
`default_nettype none

package rvex_pkg;

  localparam int XLEN = 32;
  localparam int REG_IDX_W = 5;
  localparam int IMM_W = 21;

  typedef enum logic [5:0] {
    OP_LUI    = 6'd0,
    OP_AUIPC  = 6'd1,
    OP_JAL    = 6'd2,
    OP_JALR   = 6'd3,
    OP_BEQ    = 6'd4,
    OP_BNE    = 6'd5,
    OP_BLT    = 6'd6,
    OP_BGE    = 6'd7,
    OP_BLTU   = 6'd8,
    OP_BGEU   = 6'd9,
    OP_LB     = 6'd10,
    OP_LH     = 6'd11,
    OP_LW     = 6'd12,
    OP_LBU    = 6'd13,
    OP_LHU    = 6'd14,
    OP_SB     = 6'd15,
    OP_SH     = 6'd16,
    OP_SW     = 6'd17,
    OP_ADDI   = 6'd18,
    OP_SLTI   = 6'd19,
    OP_SLTIU  = 6'd20,
    OP_XORI   = 6'd21,
    OP_ORI    = 6'd22,
    OP_ANDI   = 6'd23,
    OP_SLLI   = 6'd24,
    OP_SRLI   = 6'd25,
    OP_SRAI   = 6'd26,
    OP_ADD    = 6'd27,
    OP_SUB    = 6'd28,
    OP_SLL    = 6'd29,
    OP_SLT    = 6'd30,
    OP_SLTU   = 6'd31,
    OP_XOR    = 6'd32,
    OP_SRL    = 6'd33,
    OP_SRA    = 6'd34,
    OP_OR     = 6'd35,
    OP_AND    = 6'd36
  } op_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } mem_size_t;

  // register file write port
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] addr;
    logic [XLEN-1:0]      data;
  } rf_wr_t;

  // one executed instruction
  typedef struct packed {
    logic [XLEN-1:0]      next_pc;
    logic                 mem_valid;
    logic                 mem_write;
    logic [1:0]           mem_size;
    logic [XLEN-1:0]      mem_address;
    logic [XLEN-1:0]      mem_wdata;
    logic                 wb_valid;
    logic [REG_IDX_W-1:0] wb_index;
    logic [XLEN-1:0]      wb_value;
    logic                 trap;
  } exec_res_t;

endpackage

`default_nettype wire

FILE: hdl/rvex_regfile.sv
// rvex_regfile: integer register file, one write and two registered reads
// per-entry valid bits make never-written registers read as zero
// depends on rvex_pkg
`default_nettype none

module rvex_regfile
  import rvex_pkg::*;
#(
  parameter int REGISTER_COUNT = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rd_en,
  input  wire logic [REG_IDX_W-1:0] rd_addr1,
  input  wire logic [REG_IDX_W-1:0] rd_addr2,
  input  wire rf_wr_t               wr,
  output logic      [XLEN-1:0]      rd_data1,
  output logic      [XLEN-1:0]      rd_data2
);

  localparam int IDX_W = $clog2(REGISTER_COUNT);
  localparam logic [REG_IDX_W:0] REG_LIMIT = (REG_IDX_W+1)'(REGISTER_COUNT);

  logic [XLEN-1:0]           regs_r [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid_r;
  logic [XLEN-1:0]           q1_r, q2_r, byp_data_r;
  logic                      live1_r, live2_r, byp1_r, byp2_r;
  logic                      live1_nxt, live2_nxt;

  // a source is live when nonzero, inside the file and written before
  assign live1_nxt = (rd_addr1 != '0) && ({1'b0, rd_addr1} < REG_LIMIT) &&
                     valid_r[rd_addr1[IDX_W-1:0]];
  assign live2_nxt = (rd_addr2 != '0) && ({1'b0, rd_addr2} < REG_LIMIT) &&
                     valid_r[rd_addr2[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      regs_r[wr.addr[IDX_W-1:0]] <= wr.data;
    end
    if (rd_en) begin
      q1_r       <= regs_r[rd_addr1[IDX_W-1:0]];
      q2_r       <= regs_r[rd_addr2[IDX_W-1:0]];
      byp_data_r <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      live1_r <= 1'b0;
      live2_r <= 1'b0;
      byp1_r  <= 1'b0;
      byp2_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr[IDX_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        live1_r <= live1_nxt;
        live2_r <= live2_nxt;
        // write in the same cycle wins over the old array contents
        byp1_r  <= wr.en && (wr.addr == rd_addr1);
        byp2_r  <= wr.en && (wr.addr == rd_addr2);
      end
    end
  end

  assign rd_data1 = byp1_r ? byp_data_r : (live1_r ? q1_r : '0);
  assign rd_data2 = byp2_r ? byp_data_r : (live2_r ? q2_r : '0);

endmodule

`default_nettype wire

FILE: hdl/rvex_alu.sv
// rvex_alu: combinational execute of one decoded rv32i instruction
// computes write-back, memory request, next pc and trap
// depends on rvex_pkg
`default_nettype none

module rvex_alu
  import rvex_pkg::*;
#(
  parameter int REGISTER_COUNT = 32
) (
  input  wire logic [5:0]           op,
  input  wire logic [REG_IDX_W-1:0] rd,
  input  wire logic [XLEN-1:0]      a,
  input  wire logic [XLEN-1:0]      b,
  input  wire logic [IMM_W-1:0]     imm,
  input  wire logic [XLEN-1:0]      ldata,
  input  wire logic                 ok,
  input  wire logic [XLEN-1:0]      pc,
  output exec_res_t                 res
);

  localparam logic [REG_IDX_W:0] REG_LIMIT = (REG_IDX_W+1)'(REGISTER_COUNT);

  logic [XLEN-1:0] i12, b13, j21, u_imm;
  logic [XLEN-1:0] pc_seq, addr_sum, load_val, val;
  logic [4:0]      sh, bsh;
  logic            taken, wb, trap;
  logic [1:0]      load_size;

  assign i12    = {{(XLEN-12){imm[11]}}, imm[11:0]};
  assign b13    = {{(XLEN-13){imm[12]}}, imm[12:0]};
  assign j21    = {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
  assign u_imm  = {imm[19:0], 12'b0};
  assign sh     = imm[4:0];
  assign bsh    = b[4:0];
  assign pc_seq = pc + XLEN'(4);
  // shared by jalr, loads, stores and addi
  assign addr_sum = a + i12;

  always_comb begin
    case (op) inside
      OP_LB:   load_val = {{(XLEN-8){ldata[7]}}, ldata[7:0]};
      OP_LH:   load_val = {{(XLEN-16){ldata[15]}}, ldata[15:0]};
      OP_LBU:  load_val = {{(XLEN-8){1'b0}}, ldata[7:0]};
      OP_LHU:  load_val = {{(XLEN-16){1'b0}}, ldata[15:0]};
      default: load_val = ldata;
    endcase
    case (op) inside
      OP_LB, OP_LBU: load_size = SIZE_BYTE;
      OP_LH, OP_LHU: load_size = SIZE_HALF;
      default:       load_size = SIZE_WORD;
    endcase
  end

  always_comb begin
    res         = '0;
    res.next_pc = pc_seq;
    taken       = 1'b0;
    wb          = 1'b0;
    trap        = 1'b0;
    val         = '0;
    unique case (op) inside
      OP_LUI:   begin val = u_imm;          wb = 1'b1; end
      OP_AUIPC: begin val = pc + u_imm;     wb = 1'b1; end
      OP_JAL: begin
        val = pc_seq;
        wb  = 1'b1;
        res.next_pc = pc + j21;
      end
      OP_JALR: begin
        val = pc_seq;
        wb  = 1'b1;
        res.next_pc = {addr_sum[XLEN-1:1], 1'b0};
      end
      OP_BEQ:  taken = (a == b);
      OP_BNE:  taken = (a != b);
      OP_BLT:  taken = ($signed(a) < $signed(b));
      OP_BGE:  taken = !($signed(a) < $signed(b));
      OP_BLTU: taken = (a < b);
      OP_BGEU: taken = (a >= b);
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        res.mem_valid   = 1'b1;
        res.mem_address = addr_sum;
        res.mem_size    = load_size;
        if (ok) begin
          val = load_val;
          wb  = 1'b1;
        end else begin
          trap = 1'b1;
        end
      end
      OP_SB, OP_SH, OP_SW: begin
        res.mem_valid   = 1'b1;
        res.mem_write   = 1'b1;
        res.mem_address = addr_sum;
        trap            = !ok;
        case (op) inside
          OP_SB: begin
            res.mem_size  = SIZE_BYTE;
            res.mem_wdata = {{(XLEN-8){1'b0}}, b[7:0]};
          end
          OP_SH: begin
            res.mem_size  = SIZE_HALF;
            res.mem_wdata = {{(XLEN-16){1'b0}}, b[15:0]};
          end
          default: begin
            res.mem_size  = SIZE_WORD;
            res.mem_wdata = b;
          end
        endcase
      end
      OP_ADDI:  begin val = addr_sum;                                wb = 1'b1; end
      OP_SLTI:  begin val = XLEN'($signed(a) < $signed(i12));        wb = 1'b1; end
      OP_SLTIU: begin val = XLEN'(a < i12);                          wb = 1'b1; end
      OP_XORI:  begin val = a ^ i12;                                 wb = 1'b1; end
      OP_ORI:   begin val = a | i12;                                 wb = 1'b1; end
      OP_ANDI:  begin val = a & i12;                                 wb = 1'b1; end
      OP_SLLI:  begin val = a << sh;                                 wb = 1'b1; end
      OP_SRLI:  begin val = a >> sh;                                 wb = 1'b1; end
      OP_SRAI:  begin val = $unsigned($signed(a) >>> sh);            wb = 1'b1; end
      OP_ADD:   begin val = a + b;                                   wb = 1'b1; end
      OP_SUB:   begin val = a - b;                                   wb = 1'b1; end
      OP_SLL:   begin val = a << bsh;                                wb = 1'b1; end
      OP_SLT:   begin val = XLEN'($signed(a) < $signed(b));          wb = 1'b1; end
      OP_SLTU:  begin val = XLEN'(a < b);                            wb = 1'b1; end
      OP_XOR:   begin val = a ^ b;                                   wb = 1'b1; end
      OP_SRL:   begin val = a >> bsh;                                wb = 1'b1; end
      OP_SRA:   begin val = $unsigned($signed(a) >>> bsh);           wb = 1'b1; end
      OP_OR:    begin val = a | b;                                   wb = 1'b1; end
      OP_AND:   begin val = a & b;                                   wb = 1'b1; end
      // fence, system, csr and unknown codes
      default:  trap = 1'b1;
    endcase

    if (taken) begin
      res.next_pc = pc + b13;
    end
    if (trap) begin
      res.next_pc = pc;
      wb          = 1'b0;
    end
    if ((rd == '0) || !({1'b0, rd} < REG_LIMIT)) begin
      wb = 1'b0;
    end
    res.trap     = trap;
    res.wb_valid = wb;
    res.wb_index = wb ? rd : '0;
    res.wb_value = wb ? val : '0;
  end

endmodule

`default_nettype wire

FILE: hdl/rv32i_execute_unit.sv
// rv32i_execute_unit: rv32i execute stage with register file and program counter
// a request passes the execute stage into the result register, waiting while it
// is full; throughput: one request per cycle when not stalled; register file read
// at accept, execute in the second stage, write-back bypassed into a same-cycle read
// reset: pc loads 0, register file valid bits clear so all registers read zero
// depends on rvex_pkg, rvex_regfile, rvex_alu
`default_nettype none

module rv32i_execute_unit
  import rvex_pkg::*;
#(
  parameter int REGISTER_COUNT = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration: start address, also loads the pc at once
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [XLEN-1:0]      cfg_start_address,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [5:0]           in_op,
  input  wire logic [REG_IDX_W-1:0] in_dest_index,
  input  wire logic [REG_IDX_W-1:0] in_src1_index,
  input  wire logic [REG_IDX_W-1:0] in_src2_index,
  input  wire logic [IMM_W-1:0]     in_immediate,
  input  wire logic [XLEN-1:0]      in_load_data,
  input  wire logic                 in_access_ok,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [XLEN-1:0]           out_next_pc,
  output logic                      out_mem_valid,
  output logic                      out_mem_write,
  output logic [1:0]                out_mem_size,
  output logic [XLEN-1:0]           out_mem_address,
  output logic [XLEN-1:0]           out_mem_wdata,
  output logic                      out_wb_valid,
  output logic [REG_IDX_W-1:0]      out_wb_index,
  output logic [XLEN-1:0]           out_wb_value,
  output logic                      out_trap
);

  // handshake
  logic in_fire, cfg_fire, s1_adv;

  // execute stage holding register
  logic                 s1_v_r, s1_v_nxt;
  logic [5:0]           s1_op_r;
  logic [REG_IDX_W-1:0] s1_rd_r;
  logic [IMM_W-1:0]     s1_imm_r;
  logic [XLEN-1:0]      s1_ldata_r;
  logic                 s1_ok_r;

  // architectural pc, updated as each instruction retires into the result register
  logic [XLEN-1:0] pc_r, pc_nxt;

  // result register
  logic      out_v_r, out_v_nxt;
  exec_res_t out_r;

  logic [XLEN-1:0] src_a, src_b;
  exec_res_t       res;
  rf_wr_t          rf_wr;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // stage 1 moves on whenever the result register is free or being drained
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign s1_v_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_comb begin
    pc_nxt = pc_r;
    if (cfg_fire) begin
      pc_nxt = cfg_start_address;
    end else if (s1_adv) begin
      pc_nxt = res.next_pc;
    end
  end

  // write-back happens at the same edge the result is registered
  always_comb begin
    rf_wr.en   = s1_adv && res.wb_valid;
    rf_wr.addr = res.wb_index;
    rf_wr.data = res.wb_value;
  end

  rvex_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .rd_addr1 (in_src1_index),
    .rd_addr2 (in_src2_index),
    .wr       (rf_wr),
    .rd_data1 (src_a),
    .rd_data2 (src_b)
  );

  rvex_alu #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_alu (
    .op    (s1_op_r),
    .rd    (s1_rd_r),
    .a     (src_a),
    .b     (src_b),
    .imm   (s1_imm_r),
    .ldata (s1_ldata_r),
    .ok    (s1_ok_r),
    .pc    (pc_r),
    .res   (res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pc_r    <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_op;
      s1_rd_r    <= in_dest_index;
      s1_imm_r   <= in_immediate;
      s1_ldata_r <= in_load_data;
      s1_ok_r    <= in_access_ok;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_v_r;
  assign out_next_pc     = out_r.next_pc;
  assign out_mem_valid   = out_r.mem_valid;
  assign out_mem_write   = out_r.mem_write;
  assign out_mem_size    = out_r.mem_size;
  assign out_mem_address = out_r.mem_address;
  assign out_mem_wdata   = out_r.mem_wdata;
  assign out_wb_valid    = out_r.wb_valid;
  assign out_wb_index    = out_r.wb_index;
  assign out_wb_value    = out_r.wb_value;
  assign out_trap        = out_r.trap;

  // x0 is never reported as written
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_r.wb_valid && (out_r.wb_index == '0)))
    else $error("write-back to x0 reported");

  // a trapping instruction neither writes a register nor moves the pc
  a_trap_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res.trap && !cfg_fire) |=> (pc_r == $past(pc_r)) && !$past(rf_wr.en))
    else $error("trap changed architectural state");

  // the pc follows the retiring instruction's next pc
  a_pc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !cfg_fire) |=> (pc_r == out_r.next_pc))
    else $error("pc out of step with retired instruction");

endmodule

`default_nettype wire
